### rtl/core/acpr_pkg.sv
// Package for the airborne position decoder: item types, sizes and the NL zone table.
// No dependencies.
package acpr_pkg;

	localparam int NlTableSize = 58;
	localparam int DivW = 47;
	localparam logic [24:0] NlScale = 25'd17578125;

	localparam logic [4:0] TcBaroLo = 5'd9;
	localparam logic [4:0] TcBaroHi = 5'd18;
	localparam logic [4:0] TcGnssLo = 5'd20;
	localparam logic [4:0] TcGnssHi = 5'd22;

	localparam logic CfgRefLat = 1'b0;
	localparam logic CfgRefLon = 1'b1;

	localparam logic [33:0] NlLimit [NlTableSize] = '{
		34'd8700000000, 34'd8653536998, 34'd8575541621, 34'd8489166191,
		34'd8399173563, 34'd8307199445, 34'd8213956981, 34'd8119801349,
		34'd8024923213, 34'd7929428225, 34'd7833374083, 34'd7736789461,
		34'd7639684391, 34'd7542056257, 34'd7443893416, 34'd7345177442,
		34'd7245884545, 34'd7145986473, 34'd7045451075, 34'd6944242631,
		34'd6842322022, 34'd6739646774, 34'd6636171008, 34'd6531845310,
		34'd6426616523, 34'd6320427479, 34'd6213216659, 34'd6104917774,
		34'd5995459277, 34'd5884763776, 34'd5772747354, 34'd5659318756,
		34'd5544378444, 34'd5427817472, 34'd5309516153, 34'd5189342469,
		34'd5067150166, 34'd4942776439, 34'd4816039128, 34'd4686733252,
		34'd4554626723, 34'd4419454951, 34'd4280914012, 34'd4138651832,
		34'd3992256684, 34'd3841241892, 34'd3685025108, 34'd3522899598,
		34'd3353993436, 34'd3177209708, 34'd2991135686, 34'd2793898710,
		34'd2582924707, 34'd2354504487, 34'd2102939493, 34'd1818626357,
		34'd1482817437, 34'd1047047130
	};

	typedef struct packed {
		logic               status;
		logic signed [18:0] altitude;
		logic               gnss;
		logic               odd;
		logic [16:0]        yraw;
		logic [16:0]        xraw;
	} cls_t;

	typedef struct packed {
		logic [5:0]         lon_zones;
		logic [31:0]        longitude;
		logic [31:0]        latitude;
		logic               odd_frame;
		logic               altitude_gnss;
		logic signed [18:0] altitude;
		logic               status;
	} res_t;

endpackage

### rtl/core/adsb_airborne_position_decode_top.sv
// ADS-B airborne position decoder top level: front classifier, queue, CPR back end, divider.
// From accept to m_tvalid: two decode passes (multiply, j, 47-step divider), NL multiply
// and search between them, output register. A wrong type code goes to the output register.
// The back end works on one transaction at a time; a waiting result holds the back end,
// the queue takes two more. Async active-low reset clears control state and both reference
// registers to zero. Uses acpr_pkg, acpr_front, acpr_div, acpr_back.
module adsb_airborne_position_decode_top import acpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // message[55:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // status, altitude, altitude_gnss, odd_frame,
	                               // latitude, longitude, lon_zones, 4 zero bits
);

	logic q_valid, q_pop;
	cls_t q_item;
	logic div_start, div_done;
	logic [DivW-1:0] div_dividend;
	logic [6:0] div_divisor;
	logic [31:0] div_quot;
	res_t res;

	acpr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	acpr_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(div_start), .dividend(div_dividend), .divisor(div_divisor),
		.done(div_done), .quotient(div_quot)
	);

	acpr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.div_start(div_start), .div_dividend(div_dividend), .div_divisor(div_divisor),
		.div_done(div_done), .div_quot(div_quot),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
	);

	assign m_tdata = {4'd0, res};

endmodule

### rtl/core/acpr_front.sv
// Front end: accepts ME fields, classifies the type code, unpacks altitude and CPR words.
// Holds a two-entry queue toward the back end. Depends on acpr_pkg.
module acpr_front import acpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // message[55:0]
	output logic        q_valid,
	output cls_t        q_item,
	input  logic        q_pop
);

	logic [7:0] b0, b1, b2, b3, b4, b5, b6;
	logic [4:0] tc;
	logic [10:0] raw11;
	logic signed [19:0] baro;
	cls_t cls;
	cls_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	always_comb begin
		{b0, b1, b2, b3, b4, b5, b6} = s_tdata;
		tc = b0[7:3];
		raw11 = {b1[7:1], b2[7:4]};
		baro = $signed({9'd0, raw11}) * (b1[0] ? 20'sd25 : 20'sd100) - 20'sd1000;
		cls = '0;
		if ((tc >= TcBaroLo && tc <= TcBaroHi) || (tc >= TcGnssLo && tc <= TcGnssHi)) begin
			cls.gnss = (tc >= TcGnssLo);
			cls.altitude = cls.gnss ? $signed({7'd0, b1, b2[7:4]}) : baro[18:0];
			cls.odd = b2[2];
			cls.yraw = {b2[1:0], b3, b4[7:1]};
			cls.xraw = {b4[0], b5, b6};
		end else begin
			cls.status = 1'b1;
		end
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

### rtl/core/acpr_div.sv
// Restoring divider, one quotient bit per cycle, for the CPR rounding division.
// Depends on acpr_pkg.
module acpr_div import acpr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [6:0]      divisor,
	output logic            done,
	output logic [31:0]     quotient
);

	logic [DivW-1:0] num_q;
	logic [6:0] rem_q, div_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [7:0] trial;
	logic qbit;
	logic [6:0] rem_nx;

	always_comb begin
		trial = {rem_q, num_q[DivW-1]};
		qbit = (trial >= {1'b0, div_q});
		rem_nx = qbit ? 7'(trial - {1'b0, div_q}) : trial[6:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DivW-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DivW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = num_q[31:0];

endmodule

### rtl/core/acpr_back.sv
// Back end: local CPR decode of latitude and longitude, NL zone search, result register.
// Holds the reference registers; uses acpr_div through ports. Depends on acpr_pkg.
module acpr_back import acpr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            q_valid,
	input  cls_t            q_item,
	output logic            q_pop,
	output logic            div_start,
	output logic [DivW-1:0] div_dividend,
	output logic [6:0]      div_divisor,
	input  logic            div_done,
	input  logic [31:0]     div_quot,
	output logic            m_tvalid,
	input  logic            m_tready,
	output res_t            m_res
);

	typedef enum logic [3:0] {
		IDLE, MUL, JCALC, DIVGO, DIVWAIT, NLMUL, NLSRCH, OUT
	} state_t;

	state_t state_q;
	cls_t item_q;
	logic signed [31:0] ref_lat_q, ref_lon_q;
	logic signed [31:0] ref_q;
	logic [16:0] cpr_q;
	logic [5:0] nz_q;
	logic lon_q;
	logic signed [39:0] prod_q;
	logic signed [8:0] j_q;
	logic [31:0] lat_q, lon_res_q;
	logic [56:0] pa_q;
	logic [5:0] lo_q, hi_q;
	logic [5:0] nl_q;
	logic out_valid_q;
	res_t res_q;

	logic signed [40:0] jsum;
	logic signed [47:0] dvd;
	logic [31:0] abs_lat;
	logic [5:0] mid;
	logic [56:0] lim;
	logic [5:0] nl_nx, nzl;
	res_t res_nx;

	always_comb begin
		jsum = 41'(prod_q) - $signed({9'd0, cpr_q, 15'd0}) + $signed(41'd1 << 31);
		dvd = 48'($signed({j_q, cpr_q, 16'd0})) + $signed({1'b0, nz_q, 41'd0})
			+ $signed({42'd0, nz_q});
		abs_lat = lat_q[31] ? 32'(~lat_q + 32'd1) : lat_q;
		mid = 6'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		lim = {2'b0, NlLimit[mid], 21'd0};
		nl_nx = lo_q + 6'd1;
		nzl = (nl_nx > {5'd0, item_q.odd}) ? 6'(nl_nx - {5'd0, item_q.odd}) : 6'd1;
		res_nx = '0;
		res_nx.status = item_q.status;
		if (!item_q.status) begin
			res_nx.altitude = item_q.altitude;
			res_nx.altitude_gnss = item_q.gnss;
			res_nx.odd_frame = item_q.odd;
			res_nx.latitude = lat_q;
			res_nx.longitude = lon_res_q;
			res_nx.lon_zones = nl_q;
		end
	end

	assign q_pop = (state_q == IDLE) && q_valid;
	assign div_start = (state_q == DIVGO);
	assign div_dividend = dvd[DivW-1:0];
	assign div_divisor = {nz_q, 1'b0};
	assign m_tvalid = out_valid_q;
	assign m_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CfgRefLat)
				ref_lat_q <= cfg_data;
			else
				ref_lon_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == OUT && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						ref_q <= ref_lat_q;
						cpr_q <= q_item.yraw;
						nz_q <= q_item.odd ? 6'd59 : 6'd60;
						lon_q <= 1'b0;
						state_q <= q_item.status ? OUT : MUL;
					end
				end
				MUL: begin
					prod_q <= ref_q * $signed({2'b0, nz_q});
					state_q <= JCALC;
				end
				JCALC: begin
					j_q <= jsum[40:32];
					state_q <= DIVGO;
				end
				DIVGO: state_q <= DIVWAIT;
				DIVWAIT: begin
					if (div_done) begin
						if (lon_q) begin
							lon_res_q <= div_quot;
							state_q <= OUT;
						end else begin
							lat_q <= div_quot;
							state_q <= NLMUL;
						end
					end
				end
				NLMUL: begin
					pa_q <= abs_lat * NlScale;
					lo_q <= '0;
					hi_q <= 6'(NlTableSize);
					state_q <= NLSRCH;
				end
				NLSRCH: begin
					if (lo_q < hi_q) begin
						if (lim > pa_q)
							lo_q <= mid + 6'd1;
						else
							hi_q <= mid;
					end else begin
						nl_q <= nl_nx;
						nz_q <= nzl;
						ref_q <= ref_lon_q;
						cpr_q <= item_q.xraw;
						lon_q <= 1'b1;
						state_q <= MUL;
					end
				end
				OUT: begin
					if (!out_valid_q || m_tready) begin
						res_q <= res_nx;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
